/* hdl/fla_pkg.sv */
// ----------------------------------------------------------------------------
// fla_pkg : shared types and constants of the free-list heap allocator
// Header word layout, arena limits and the controller's state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package fla_pkg;

    localparam int ARENA_UNITS = 4096;
    localparam int UNIT_BYTES  = 16;
    localparam int UNIT_SHIFT  = $clog2(UNIT_BYTES);
    localparam int HDR_DEPTH   = ARENA_UNITS + 1;
    localparam int ADDR_W      = $clog2(HDR_DEPTH);
    localparam int FIELD_W     = 13;
    localparam int BYTES_W     = 16;
    localparam int STEP_W      = $clog2(ARENA_UNITS + 3);
    localparam int WALK_LIMIT  = ARENA_UNITS + 2;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct packed {
        logic [FIELD_W-1:0] link;
        logic [FIELD_W-1:0] size;
    } hdr_t;

    localparam int HDR_W = $bits(hdr_t);

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_A_RD_ROVER,
        ST_A_LD,
        ST_A_RD_CUR,
        ST_A_CHK,
        ST_A_TAIL_WR,
        ST_F_RD_P,
        ST_F_CHK,
        ST_F_RD_BLK,
        ST_F_RD_NX,
        ST_F_MRG_BLK,
        ST_F_MRG_P,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

/* hdl/fla_hdr_ram.sv */
// ----------------------------------------------------------------------------
// fla_hdr_ram : header store
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fla_hdr_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 4097,
    parameter int AW    = 13
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hdl/free_list_heap_allocator_top.sv */
// ----------------------------------------------------------------------------
// free_list_heap_allocator_top : next-fit free-list heap allocator
// Address-ordered circular free list with a sentinel at unit 0, kept in one
// header RAM and walked by a read-modify-write controller.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          payload
//  s_        in         s_tvalid/s_tready  tuser: kind; tdata: byte_count,
//                                          block_unit
//  m_        out        m_tvalid/m_tready  tdata: payload_unit, success
//  cfg_      in         cfg_we             cfg_wdata: arena_units
//
//  An allocation reads the rover header, then one header per free block
//  visited, and on a split writes the tail header too; a free reads one
//  header per list node visited, then the block and its successor, and
//  writes back the block and its predecessor; a null or out-of-arena free
//  goes straight to the result. The result is valid in the same cycle as
//  the next word can be taken. Reset and each arena_units write run a sweep
//  over all 4097 header RAM entries; no word is accepted during it.
//  A waiting result sits in the output register while the next word is taken;
//  the following result holds in the controller until that register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module free_list_heap_allocator_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] byte_count, [28:16] block_unit
    input  wire logic        s_tuser,   // [0] kind
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // [12:0] payload_unit, [13] success
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [12:0] cfg_wdata
);

    localparam int AW = fla_pkg::ADDR_W;
    localparam int FW = fla_pkg::FIELD_W;
    localparam logic [FW-1:0] LIMIT = FW'(fla_pkg::ARENA_UNITS);
    localparam logic [fla_pkg::STEP_W-1:0] STEP_END = fla_pkg::STEP_W'(fla_pkg::WALK_LIMIT);

    fla_pkg::state_t state_reg, state_next;

    logic [FW-1:0] arena_reg, arena_next;
    logic [FW-1:0] rover_reg, rover_next;
    logic [FW-1:0] clr_reg, clr_next;
    logic [FW-1:0] need_reg, need_next;
    logic [FW-1:0] blk_reg, blk_next;
    logic [FW-1:0] prev_reg, prev_next;     // alloc: prev / free: p
    logic [FW-1:0] psize_reg, psize_next;
    logic [FW-1:0] cur_reg, cur_next;       // alloc: cur / free: nx
    logic [FW:0]   tail_reg, tail_next;
    logic [fla_pkg::STEP_W-1:0] steps_reg, steps_next;
    fla_pkg::hdr_t blk_ent_reg, blk_ent_next;
    logic [FW-1:0] res_unit_reg, res_unit_next;
    logic          res_ok_reg, res_ok_next;
    logic          m_valid_reg, m_valid_next;
    logic [FW-1:0] m_unit_reg, m_unit_next;
    logic          m_ok_reg, m_ok_next;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    fla_pkg::hdr_t ram_wdata, rd;
    logic [fla_pkg::HDR_W-1:0] ram_rdata;

    assign rd = fla_pkg::hdr_t'(ram_rdata);

    fla_hdr_ram #(
        .WIDTH (fla_pkg::HDR_W),
        .DEPTH (fla_pkg::HDR_DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // request fields
    logic [fla_pkg::BYTES_W-1:0] in_bytes;
    logic [FW-1:0]               in_unit;
    logic [fla_pkg::BYTES_W:0]   bytes_up;
    logic                        s_fire;

    assign in_bytes = s_tdata[15:0];
    assign in_unit  = s_tdata[28:16];
    assign bytes_up = {1'b0, in_bytes} + (fla_pkg::BYTES_W+1)'(fla_pkg::UNIT_BYTES - 1);
    assign s_fire   = s_tvalid && s_tready;

    // shared arithmetic on the word just read and the held header fields
    logic [FW-1:0] rest;
    logic [FW:0]   tail_sum;
    logic [FW:0]   blk_end;
    logic [FW:0]   p_end;
    logic          free_hit;

    assign rest     = rd.size - need_reg;
    assign tail_sum = {1'b0, cur_reg} + {1'b0, rest};
    assign blk_end  = {1'b0, blk_reg} + {1'b0, blk_ent_reg.size};
    assign p_end    = {1'b0, prev_reg} + {1'b0, psize_reg};
    assign free_hit = (blk_reg > prev_reg && blk_reg < rd.link) ||
                      (prev_reg >= rd.link && (blk_reg > prev_reg || blk_reg < rd.link));

    // next state and datapath
    always_comb begin
        state_next    = state_reg;
        arena_next    = arena_reg;
        rover_next    = rover_reg;
        clr_next      = clr_reg;
        need_next     = need_reg;
        blk_next      = blk_reg;
        prev_next     = prev_reg;
        psize_next    = psize_reg;
        cur_next      = cur_reg;
        tail_next     = tail_reg;
        steps_next    = steps_reg;
        blk_ent_next  = blk_ent_reg;
        res_unit_next = res_unit_reg;
        res_ok_next   = res_ok_reg;
        m_valid_next  = m_valid_reg;
        m_unit_next   = m_unit_reg;
        m_ok_next     = m_ok_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            fla_pkg::ST_CLR: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LIMIT) begin
                    rover_next = '0;
                    state_next = fla_pkg::ST_IDLE;
                end
            end
            fla_pkg::ST_IDLE: begin
                if (s_fire) begin
                    res_unit_next = '0;
                    res_ok_next   = 1'b0;
                    if (s_tuser == fla_pkg::KIND_ALLOC) begin
                        need_next  = FW'(bytes_up >> fla_pkg::UNIT_SHIFT) + 1'b1;
                        state_next = fla_pkg::ST_A_RD_ROVER;
                    end else if (in_unit == '0) begin
                        res_ok_next = 1'b1;
                        state_next  = fla_pkg::ST_RESP;
                    end else if (in_unit == FW'(1) || (in_unit - 1'b1) > arena_reg) begin
                        state_next = fla_pkg::ST_RESP;
                    end else begin
                        blk_next   = in_unit - 1'b1;
                        prev_next  = rover_reg;
                        steps_next = '0;
                        state_next = fla_pkg::ST_F_RD_P;
                    end
                end
            end
            fla_pkg::ST_A_RD_ROVER: begin
                state_next = (rover_reg > LIMIT) ? fla_pkg::ST_RESP : fla_pkg::ST_A_LD;
            end
            fla_pkg::ST_A_LD: begin
                prev_next  = rover_reg;
                psize_next = rd.size;
                cur_next   = rd.link;
                steps_next = '0;
                state_next = fla_pkg::ST_A_RD_CUR;
            end
            fla_pkg::ST_A_RD_CUR: begin
                state_next = (cur_reg > LIMIT) ? fla_pkg::ST_RESP : fla_pkg::ST_A_CHK;
            end
            fla_pkg::ST_A_CHK: begin
                if (rd.size >= need_reg) begin
                    if (rd.size == need_reg) begin
                        rover_next    = prev_reg;
                        res_unit_next = cur_reg + 1'b1;
                        res_ok_next   = 1'b1;
                        state_next    = fla_pkg::ST_RESP;
                    end else if (tail_sum > {1'b0, LIMIT}) begin
                        state_next = fla_pkg::ST_RESP;
                    end else begin
                        tail_next  = tail_sum;
                        state_next = fla_pkg::ST_A_TAIL_WR;
                    end
                end else if (cur_reg == rover_reg ||
                             steps_reg + 1'b1 == STEP_END) begin
                    state_next = fla_pkg::ST_RESP;
                end else begin
                    steps_next = steps_reg + 1'b1;
                    prev_next  = cur_reg;
                    psize_next = rd.size;
                    cur_next   = rd.link;
                    state_next = fla_pkg::ST_A_RD_CUR;
                end
            end
            fla_pkg::ST_A_TAIL_WR: begin
                rover_next    = prev_reg;
                res_unit_next = tail_reg[FW-1:0] + 1'b1;
                res_ok_next   = 1'b1;
                state_next    = fla_pkg::ST_RESP;
            end
            fla_pkg::ST_F_RD_P: begin
                state_next = (prev_reg > LIMIT) ? fla_pkg::ST_RESP : fla_pkg::ST_F_CHK;
            end
            fla_pkg::ST_F_CHK: begin
                psize_next = rd.size;
                cur_next   = rd.link;
                if (rd.link > LIMIT) begin
                    state_next = fla_pkg::ST_RESP;
                end else if (free_hit) begin
                    state_next = fla_pkg::ST_F_RD_BLK;
                end else if (steps_reg + 1'b1 == STEP_END) begin
                    state_next = fla_pkg::ST_RESP;
                end else begin
                    steps_next = steps_reg + 1'b1;
                    prev_next  = rd.link;
                    state_next = fla_pkg::ST_F_RD_P;
                end
            end
            fla_pkg::ST_F_RD_BLK: begin
                state_next = fla_pkg::ST_F_RD_NX;
            end
            fla_pkg::ST_F_RD_NX: begin
                blk_ent_next = rd;
                state_next   = fla_pkg::ST_F_MRG_BLK;
            end
            fla_pkg::ST_F_MRG_BLK: begin
                if (blk_end == {1'b0, cur_reg}) begin
                    blk_ent_next.size = blk_ent_reg.size + rd.size;
                    blk_ent_next.link = rd.link;
                end else begin
                    blk_ent_next.link = cur_reg;
                end
                state_next = fla_pkg::ST_F_MRG_P;
            end
            fla_pkg::ST_F_MRG_P: begin
                rover_next  = prev_reg;
                res_ok_next = 1'b1;
                state_next  = fla_pkg::ST_RESP;
            end
            fla_pkg::ST_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_unit_next  = res_unit_reg;
                    m_ok_next    = res_ok_reg;
                    state_next   = fla_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fla_pkg::ST_IDLE;
            end
        endcase

        // rebuild the heap on any write of the arena length
        if (cfg_we) begin
            if (cfg_wdata < FW'(2)) begin
                arena_next = FW'(2);
            end else if (cfg_wdata > LIMIT) begin
                arena_next = LIMIT;
            end else begin
                arena_next = cfg_wdata;
            end
            clr_next   = '0;
            state_next = fla_pkg::ST_CLR;
        end
    end

    // RAM control and handshake outputs
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;

        case (state_reg)
            fla_pkg::ST_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(clr_reg);
                if (clr_reg == '0) begin
                    ram_wdata.link = FW'(1);
                end else if (clr_reg == FW'(1)) begin
                    ram_wdata.size = arena_reg;
                end
            end
            fla_pkg::ST_A_RD_ROVER: begin
                ram_re    = 1'b1;
                ram_raddr = AW'(rover_reg);
            end
            fla_pkg::ST_A_RD_CUR: begin
                ram_re    = 1'b1;
                ram_raddr = AW'(cur_reg);
            end
            fla_pkg::ST_A_CHK: begin
                if (rd.size == need_reg) begin
                    // exact fit: unlink the block from prev
                    ram_we         = 1'b1;
                    ram_waddr      = AW'(prev_reg);
                    ram_wdata.link = rd.link;
                    ram_wdata.size = psize_reg;
                end else if (rd.size > need_reg && tail_sum <= {1'b0, LIMIT}) begin
                    // shrink the block and fetch the tail header
                    ram_we         = 1'b1;
                    ram_waddr      = AW'(cur_reg);
                    ram_wdata.link = rd.link;
                    ram_wdata.size = rest;
                    ram_re         = 1'b1;
                    ram_raddr      = AW'(tail_sum);
                end
            end
            fla_pkg::ST_A_TAIL_WR: begin
                ram_we         = 1'b1;
                ram_waddr      = AW'(tail_reg);
                ram_wdata.link = rd.link;
                ram_wdata.size = need_reg;
            end
            fla_pkg::ST_F_RD_P: begin
                ram_re    = 1'b1;
                ram_raddr = AW'(prev_reg);
            end
            fla_pkg::ST_F_RD_BLK: begin
                ram_re    = 1'b1;
                ram_raddr = AW'(blk_reg);
            end
            fla_pkg::ST_F_RD_NX: begin
                ram_re    = 1'b1;
                ram_raddr = AW'(cur_reg);
            end
            fla_pkg::ST_F_MRG_BLK: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(blk_reg);
                if (blk_end == {1'b0, cur_reg}) begin
                    ram_wdata.size = blk_ent_reg.size + rd.size;
                    ram_wdata.link = rd.link;
                end else begin
                    ram_wdata.size = blk_ent_reg.size;
                    ram_wdata.link = cur_reg;
                end
            end
            fla_pkg::ST_F_MRG_P: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(prev_reg);
                if (p_end == {1'b0, blk_reg}) begin
                    ram_wdata.size = psize_reg + blk_ent_reg.size;
                    ram_wdata.link = blk_ent_reg.link;
                end else begin
                    ram_wdata.size = psize_reg;
                    ram_wdata.link = blk_reg;
                end
            end
            default: ;
        endcase
    end

    assign s_tready = (state_reg == fla_pkg::ST_IDLE) && !cfg_we;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_ok_reg, m_unit_reg};

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fla_pkg::ST_CLR;
            arena_reg   <= LIMIT;
            rover_reg   <= '0;
            clr_reg     <= '0;
            steps_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            arena_reg   <= arena_next;
            rover_reg   <= rover_next;
            clr_reg     <= clr_next;
            steps_reg   <= steps_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        need_reg     <= need_next;
        blk_reg      <= blk_next;
        prev_reg     <= prev_next;
        psize_reg    <= psize_next;
        cur_reg      <= cur_next;
        tail_reg     <= tail_next;
        blk_ent_reg  <= blk_ent_next;
        res_unit_reg <= res_unit_next;
        res_ok_reg   <= res_ok_next;
        m_unit_reg   <= m_unit_next;
        m_ok_reg     <= m_ok_next;
    end

endmodule

`default_nettype wire
